/* rtl/ccyg_pkg.sv */
// Shared types, constants and a helper function for the carrot-chase yaw guidance block.
package ccyg_pkg;

  // Datapath widths.
  localparam int unsigned DW = 40;   // CORDIC vector and position datapath
  localparam int unsigned AW = 21;   // angle accumulator
  localparam int unsigned QW = 13;   // unwrap turn count
  localparam int unsigned CFG_DW = 31;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CORDIC_ITERATIONS_DEF = 16;

  // Angles in 2^-16 rad.
  localparam logic signed [AW-1:0] PI_Q      = AW'(205887);
  localparam logic signed [AW-1:0] HALF_PI_Q = AW'(102944);
  localparam logic [18:0]          TWO_PI_Q  = 19'd411775;
  localparam logic [29:0]          INV_GAIN  = 30'd652032874;

  // Turn count by reciprocal multiplication: estimate, then one correction step.
  localparam int unsigned DIV_STEPS   = 3;
  localparam int unsigned RECIP_SHIFT = 50;
  localparam logic [31:0] RECIP       = 32'((64'd1 << RECIP_SHIFT) / 64'(TWO_PI_Q));

  // Configuration register indexes and reset values.
  localparam logic [CFG_AW-1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LEAD      = 2'd1;
  localparam logic [CFG_AW-1:0] REG_RADIUS    = 2'd2;
  localparam logic [30:0] LOOKAHEAD_RST = 31'd327680;
  localparam logic [17:0] LEAD_RST      = 18'd51472;
  localparam logic [30:0] RADIUS_RST    = 31'd655360;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ATAN_INIT,
    OP_ATAN_ITER,
    OP_ATAN_END,
    OP_ROT_INIT,
    OP_ROT_ITER,
    OP_GAIN_MUL,
    OP_GAIN_END,
    OP_CARROT,
    OP_UNWRAP_INIT,
    OP_DIV_STEP,
    OP_UNWRAP_END
  } op_e;

  // Operand selects; their meaning depends on the operation.
  localparam logic [1:0] SEL_SEG    = 2'd0;  // atan2: segment direction
  localparam logic [1:0] SEL_POS    = 2'd1;  // atan2 / rotate: position from anchor
  localparam logic [1:0] SEL_CARROT = 2'd2;  // atan2: carrot from position
  localparam logic [1:0] SEL_THETA  = 2'd0;  // atan end: store segment angle
  localparam logic [1:0] SEL_YAW    = 2'd1;  // atan end: store negated yaw
  localparam logic [1:0] SEL_GLEN   = 2'd2;  // rotate: gain-corrected length by theta
  localparam logic [1:0] SEL_CIRC   = 2'd3;  // rotate: radius by theta plus/minus lead
  localparam logic [1:0] SEL_X      = 2'd0;  // gain: x register
  localparam logic [1:0] SEL_LEN    = 2'd1;  // gain: |projection| plus lookahead
  localparam logic [1:0] SEL_RADIUS = 2'd2;  // gain: circle radius

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic circle;
  } status_t;

  function automatic logic [16:0] step_angle(input logic [4:0] i);
    logic [16:0] r;
    unique case (i)
      5'd0: r = 17'd51472;
      5'd1: r = 17'd30386;
      5'd2: r = 17'd16055;
      5'd3: r = 17'd8150;
      5'd4: r = 17'd4091;
      5'd5: r = 17'd2047;
      5'd6: r = 17'd1024;
      default: r = (i <= 5'd16) ? (17'd1 << (5'd16 - i)) : 17'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/ccyg_ctrl.sv */
// Sequencer that steps the guidance datapath through the CORDIC passes and the unwrap.
module ccyg_ctrl #(
  parameter int unsigned CORDIC_ITERATIONS = ccyg_pkg::CORDIC_ITERATIONS_DEF,
  parameter int unsigned CW = ($clog2(CORDIC_ITERATIONS) > 4) ? $clog2(CORDIC_ITERATIONS) : 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ccyg_pkg::status_t status_i,
  output ccyg_pkg::cmd_t    cmd_o,
  output logic [CW-1:0]     iter_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_A1_INIT = 5'd1;
  localparam logic [4:0] S_A1_ITER = 5'd2;
  localparam logic [4:0] S_A1_END  = 5'd3;
  localparam logic [4:0] S_R1_INIT = 5'd4;
  localparam logic [4:0] S_R1_ITER = 5'd5;
  localparam logic [4:0] S_G1_MUL  = 5'd6;
  localparam logic [4:0] S_G1_END  = 5'd7;
  localparam logic [4:0] S_G2_MUL  = 5'd8;
  localparam logic [4:0] S_G2_END  = 5'd9;
  localparam logic [4:0] S_R2_INIT = 5'd10;
  localparam logic [4:0] S_R2_ITER = 5'd11;
  localparam logic [4:0] S_GC_MUL  = 5'd12;
  localparam logic [4:0] S_GC_END  = 5'd13;
  localparam logic [4:0] S_RC_INIT = 5'd14;
  localparam logic [4:0] S_RC_ITER = 5'd15;
  localparam logic [4:0] S_CARROT  = 5'd16;
  localparam logic [4:0] S_A2_INIT = 5'd17;
  localparam logic [4:0] S_A2_ITER = 5'd18;
  localparam logic [4:0] S_A2_END  = 5'd19;
  localparam logic [4:0] S_U_INIT  = 5'd20;
  localparam logic [4:0] S_U_DIV   = 5'd21;
  localparam logic [4:0] S_U_END   = 5'd22;

  localparam logic [CW-1:0] ITER_LAST = CW'(CORDIC_ITERATIONS - 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(ccyg_pkg::DIV_STEPS - 1);

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign iter_o      = cnt_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = ccyg_pkg::OP_NONE;
    cmd_o.sel   = ccyg_pkg::SEL_SEG;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ccyg_pkg::OP_LOAD;
          state_d  = S_A1_INIT;
        end
      end
      S_A1_INIT: begin
        cmd_o.op  = ccyg_pkg::OP_ATAN_INIT;
        cmd_o.sel = status_i.circle ? ccyg_pkg::SEL_POS : ccyg_pkg::SEL_SEG;
        cnt_d     = '0;
        state_d   = S_A1_ITER;
      end
      S_A1_ITER: begin
        cmd_o.op = ccyg_pkg::OP_ATAN_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ITER_LAST) state_d = S_A1_END;
      end
      S_A1_END: begin
        cmd_o.op  = ccyg_pkg::OP_ATAN_END;
        cmd_o.sel = ccyg_pkg::SEL_THETA;
        state_d   = status_i.circle ? S_GC_MUL : S_R1_INIT;
      end
      S_R1_INIT: begin
        cmd_o.op  = ccyg_pkg::OP_ROT_INIT;
        cmd_o.sel = ccyg_pkg::SEL_POS;
        cnt_d     = '0;
        state_d   = S_R1_ITER;
      end
      S_R1_ITER: begin
        cmd_o.op = ccyg_pkg::OP_ROT_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ITER_LAST) state_d = S_G1_MUL;
      end
      S_G1_MUL: begin
        cmd_o.op  = ccyg_pkg::OP_GAIN_MUL;
        cmd_o.sel = ccyg_pkg::SEL_X;
        state_d   = S_G1_END;
      end
      S_G1_END: begin
        cmd_o.op = ccyg_pkg::OP_GAIN_END;
        state_d  = S_G2_MUL;
      end
      S_G2_MUL: begin
        cmd_o.op  = ccyg_pkg::OP_GAIN_MUL;
        cmd_o.sel = ccyg_pkg::SEL_LEN;
        state_d   = S_G2_END;
      end
      S_G2_END: begin
        cmd_o.op = ccyg_pkg::OP_GAIN_END;
        state_d  = S_R2_INIT;
      end
      S_R2_INIT: begin
        cmd_o.op  = ccyg_pkg::OP_ROT_INIT;
        cmd_o.sel = ccyg_pkg::SEL_GLEN;
        cnt_d     = '0;
        state_d   = S_R2_ITER;
      end
      S_R2_ITER: begin
        cmd_o.op = ccyg_pkg::OP_ROT_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ITER_LAST) state_d = S_CARROT;
      end
      S_GC_MUL: begin
        cmd_o.op  = ccyg_pkg::OP_GAIN_MUL;
        cmd_o.sel = ccyg_pkg::SEL_RADIUS;
        state_d   = S_GC_END;
      end
      S_GC_END: begin
        cmd_o.op = ccyg_pkg::OP_GAIN_END;
        state_d  = S_RC_INIT;
      end
      S_RC_INIT: begin
        cmd_o.op  = ccyg_pkg::OP_ROT_INIT;
        cmd_o.sel = ccyg_pkg::SEL_CIRC;
        cnt_d     = '0;
        state_d   = S_RC_ITER;
      end
      S_RC_ITER: begin
        cmd_o.op = ccyg_pkg::OP_ROT_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ITER_LAST) state_d = S_CARROT;
      end
      S_CARROT: begin
        cmd_o.op = ccyg_pkg::OP_CARROT;
        state_d  = S_A2_INIT;
      end
      S_A2_INIT: begin
        cmd_o.op  = ccyg_pkg::OP_ATAN_INIT;
        cmd_o.sel = ccyg_pkg::SEL_CARROT;
        cnt_d     = '0;
        state_d   = S_A2_ITER;
      end
      S_A2_ITER: begin
        cmd_o.op = ccyg_pkg::OP_ATAN_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ITER_LAST) state_d = S_A2_END;
      end
      S_A2_END: begin
        cmd_o.op  = ccyg_pkg::OP_ATAN_END;
        cmd_o.sel = ccyg_pkg::SEL_YAW;
        state_d   = S_U_INIT;
      end
      S_U_INIT: begin
        cmd_o.op = ccyg_pkg::OP_UNWRAP_INIT;
        cnt_d    = '0;
        state_d  = S_U_DIV;
      end
      S_U_DIV: begin
        cmd_o.op = ccyg_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) state_d = S_U_END;
      end
      S_U_END: begin
        // The last-yaw register is also the output data, so it only moves once
        // the previous item has left.
        if (out_free) begin
          cmd_o.op    = ccyg_pkg::OP_UNWRAP_END;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/ccyg_dp.sv */
// Guidance datapath: shared CORDIC unit, gain correction, carrot point and yaw unwrap.
module ccyg_dp #(
  parameter int unsigned CW = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ccyg_pkg::CFG_AW-1:0]    cfg_idx_i,
  input  logic [ccyg_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                           cmd_i,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic signed [31:0]             anchor_x_i,
  input  logic signed [31:0]             anchor_y_i,
  input  logic signed [31:0]             end_x_i,
  input  logic signed [31:0]             end_y_i,
  input  logic                           turn_left_i,
  input  ccyg_pkg::cmd_t                 ctrl_i,
  input  logic [CW-1:0]                  iter_i,
  output ccyg_pkg::status_t              status_o,
  output logic signed [31:0]             desired_yaw_o
);

  localparam int unsigned DW = ccyg_pkg::DW;
  localparam int unsigned AW = ccyg_pkg::AW;
  localparam int unsigned QW = ccyg_pkg::QW;
  localparam int unsigned RW = 35;

  // Steps of the turn count.
  localparam logic [CW-1:0] DIV_MUL = CW'(0);
  localparam logic [CW-1:0] DIV_EST = CW'(1);

  // Configuration.
  logic [30:0] lookahead_q;
  logic [17:0] lead_q;
  logic [30:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookahead_q <= ccyg_pkg::LOOKAHEAD_RST;
      lead_q      <= ccyg_pkg::LEAD_RST;
      radius_q    <= ccyg_pkg::RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccyg_pkg::REG_LOOKAHEAD: lookahead_q <= cfg_data_i;
        ccyg_pkg::REG_LEAD:      lead_q      <= cfg_data_i[17:0];
        ccyg_pkg::REG_RADIUS:    radius_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured item.
  logic               circle_q, left_q;
  logic signed [31:0] px_q, py_q, ax_q, ay_q, ex_q, ey_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == ccyg_pkg::OP_LOAD) begin
      circle_q <= cmd_i;
      left_q   <= turn_left_i;
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      ax_q     <= anchor_x_i;
      ay_q     <= anchor_y_i;
      ex_q     <= end_x_i;
      ey_q     <= end_y_i;
    end
  end

  assign status_o.circle = circle_q;

  // Working registers.
  logic signed [DW-1:0] x_q, x_d, y_q, y_d, g_q, g_d, cx_q, cx_d, cy_q, cy_d;
  logic signed [AW-1:0] z_q, z_d, theta_q, theta_d, yaw_q, yaw_d;
  logic                 zero_q, zero_d, gneg_q, gneg_d, qneg_q, qneg_d;
  logic [53:0]          hi_q, hi_d;
  logic [45:0]          lo_q, lo_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [QW-1:0]        quo_q, quo_d;
  logic [63:0]          rcp_q, rcp_d;
  logic signed [31:0]   last_q, last_d;

  // Shared combinational terms.
  logic signed [DW-1:0] dpx, dpy, vx, vy, xs, ys, gsrc, gabs;
  logic signed [AW-1:0] st, ang, zc;
  logic [4:0]           sh;
  logic [39:0]          gmag;
  logic [54:0]          gsum;
  logic signed [33:0]   dd;
  logic signed [34:0]   off;
  logic [31:0]          prod;
  logic signed [35:0]   yfin;

  assign sh   = 5'(iter_i);
  assign st   = AW'(ccyg_pkg::step_angle(sh));
  assign xs   = x_q >>> sh;
  assign ys   = y_q >>> sh;
  assign dpx  = DW'(px_q) - DW'(ax_q);
  assign dpy  = DW'(py_q) - DW'(ay_q);
  assign gabs = g_q[DW-1] ? -g_q : g_q;
  assign zc   = zero_q ? '0 :
                (z_q > ccyg_pkg::PI_Q) ? ccyg_pkg::PI_Q :
                (z_q < -ccyg_pkg::PI_Q) ? -ccyg_pkg::PI_Q : z_q;
  assign gsum = 55'(hi_q) + 55'(lo_q[45:16]);
  assign dd   = 34'(yaw_q) - 34'(last_q);
  assign prod = 32'(quo_q) * 32'(ccyg_pkg::TWO_PI_Q);
  assign desired_yaw_o = last_q;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; g_d = g_q; cx_d = cx_q; cy_d = cy_q;
    theta_d = theta_q; yaw_d = yaw_q; zero_d = zero_q; gneg_d = gneg_q;
    hi_d = hi_q; lo_d = lo_q; rem_d = rem_q; quo_d = quo_q; qneg_d = qneg_q;
    rcp_d = rcp_q; last_d = last_q;
    vx = '0; vy = '0; ang = '0; gsrc = '0; gmag = '0; off = '0; yfin = '0;
    unique case (ctrl_i.op)
      ccyg_pkg::OP_ATAN_INIT: begin
        unique case (ctrl_i.sel)
          ccyg_pkg::SEL_POS: begin
            vx = dpx; vy = dpy;
          end
          ccyg_pkg::SEL_CARROT: begin
            vx = cx_q - DW'(px_q); vy = cy_q - DW'(py_q);
          end
          default: begin
            vx = DW'(ex_q) - DW'(ax_q); vy = DW'(ey_q) - DW'(ay_q);
          end
        endcase
        zero_d = (vx == '0) && (vy == '0);
        if (vx < 0) begin
          z_d = (vy >= 0) ? ccyg_pkg::PI_Q : -ccyg_pkg::PI_Q;
          x_d = -vx;
          y_d = -vy;
        end else begin
          z_d = '0;
          x_d = vx;
          y_d = vy;
        end
      end
      ccyg_pkg::OP_ATAN_ITER: begin
        if (y_q > 0) begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + st;
        end else begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - st;
        end
      end
      ccyg_pkg::OP_ATAN_END: begin
        if (ctrl_i.sel == ccyg_pkg::SEL_YAW) yaw_d = -zc;
        else theta_d = zc;
      end
      ccyg_pkg::OP_ROT_INIT: begin
        unique case (ctrl_i.sel)
          ccyg_pkg::SEL_POS: begin
            vx = dpx; vy = dpy; ang = -theta_q;
          end
          ccyg_pkg::SEL_CIRC: begin
            vx = g_q; vy = '0;
            ang = left_q ? theta_q + AW'(lead_q) : theta_q - AW'(lead_q);
          end
          default: begin
            vx = g_q; vy = '0; ang = theta_q;
          end
        endcase
        // One wrap suffices: the angle never leaves plus/minus three pi.
        if (ang > ccyg_pkg::PI_Q) ang = ang - AW'(ccyg_pkg::TWO_PI_Q);
        else if (ang < -ccyg_pkg::PI_Q) ang = ang + AW'(ccyg_pkg::TWO_PI_Q);
        if (ang > ccyg_pkg::HALF_PI_Q) begin
          z_d = ang - ccyg_pkg::PI_Q; x_d = -vx; y_d = -vy;
        end else if (ang < -ccyg_pkg::HALF_PI_Q) begin
          z_d = ang + ccyg_pkg::PI_Q; x_d = -vx; y_d = -vy;
        end else begin
          z_d = ang; x_d = vx; y_d = vy;
        end
      end
      ccyg_pkg::OP_ROT_ITER: begin
        if (z_q >= 0) begin
          x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - st;
        end else begin
          x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + st;
        end
      end
      ccyg_pkg::OP_GAIN_MUL: begin
        unique case (ctrl_i.sel)
          ccyg_pkg::SEL_LEN:    gsrc = gabs + DW'(lookahead_q);
          ccyg_pkg::SEL_RADIUS: gsrc = DW'(radius_q);
          default:              gsrc = x_q;
        endcase
        gneg_d = gsrc[DW-1];
        gmag   = gsrc[DW-1] ? 40'(-gsrc) : 40'(gsrc);
        hi_d   = 54'(gmag[39:16]) * 54'(ccyg_pkg::INV_GAIN);
        lo_d   = 46'(gmag[15:0]) * 46'(ccyg_pkg::INV_GAIN);
      end
      ccyg_pkg::OP_GAIN_END: begin
        g_d = gneg_q ? -DW'(gsum >> 14) : DW'(gsum >> 14);
      end
      ccyg_pkg::OP_CARROT: begin
        cx_d = DW'(ax_q) + x_q;
        cy_d = DW'(ay_q) + y_q;
      end
      ccyg_pkg::OP_UNWRAP_INIT: begin
        off    = (dd < 0) ? 35'(dd) - 35'(ccyg_pkg::PI_Q) : 35'(dd) + 35'(ccyg_pkg::PI_Q);
        qneg_d = dd < 0;
        quo_d  = '0;
        if (dd >= 34'(ccyg_pkg::PI_Q) || dd <= -34'(ccyg_pkg::PI_Q))
          rem_d = (off < 0) ? RW'(-off) : RW'(off);
        else
          rem_d = '0;
      end
      ccyg_pkg::OP_DIV_STEP: begin
        // The reciprocal estimate is at most one short of the true count.
        if (iter_i == DIV_MUL) begin
          rcp_d = 64'(rem_q[31:0]) * 64'(ccyg_pkg::RECIP);
        end else if (iter_i == DIV_EST) begin
          quo_d = QW'(rcp_q >> ccyg_pkg::RECIP_SHIFT);
        end else if (rem_q - RW'(prod) >= RW'(ccyg_pkg::TWO_PI_Q)) begin
          quo_d = quo_q + 1'b1;
        end
      end
      ccyg_pkg::OP_UNWRAP_END: begin
        yfin = qneg_q ? 36'(yaw_q) + 36'(prod) : 36'(yaw_q) - 36'(prod);
        if (yfin > 36'sd2147483647) last_d = 32'sh7FFFFFFF;
        else if (yfin < -36'sd2147483648) last_d = 32'sh80000000;
        else last_d = 32'(yfin);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; g_q <= g_d; cx_q <= cx_d; cy_q <= cy_d;
    theta_q <= theta_d; yaw_q <= yaw_d; zero_q <= zero_d; gneg_q <= gneg_d;
    hi_q <= hi_d; lo_q <= lo_d; rem_q <= rem_d; quo_q <= quo_d; qneg_q <= qneg_d;
    rcp_q <= rcp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

/* rtl/carrot_chase_yaw_guidance.sv */
// Top level of the carrot-chase yaw guidance block.
// One item is in work at a time, set by the single shared CORDIC unit and the
// three-step unwrap turn count; the next item is accepted the cycle after a result
// is written, even while that result still waits at the output.
// Reset clears the last yaw to zero and loads the default configuration.
module carrot_chase_yaw_guidance #(
  parameter int unsigned CORDIC_ITERATIONS = ccyg_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ccyg_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [ccyg_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic signed [31:0]          anchor_x_i,
  input  logic signed [31:0]          anchor_y_i,
  input  logic signed [31:0]          end_x_i,
  input  logic signed [31:0]          end_y_i,
  input  logic                        turn_left_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          desired_yaw_o
);

  localparam int unsigned CW = ($clog2(CORDIC_ITERATIONS) > 4) ? $clog2(CORDIC_ITERATIONS) : 4;

  ccyg_pkg::cmd_t    cmd;
  ccyg_pkg::status_t status;
  logic [CW-1:0]     iter;

  ccyg_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
    .CW(CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .iter_o     (iter)
  );

  ccyg_dp #(
    .CW(CW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .anchor_x_i   (anchor_x_i),
    .anchor_y_i   (anchor_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .turn_left_i  (turn_left_i),
    .ctrl_i       (cmd),
    .iter_i       (iter),
    .status_o     (status),
    .desired_yaw_o(desired_yaw_o)
  );

endmodule

/* dv/carrot_chase_yaw_guidance_tb.sv */
// Self-checking testbench for the carrot-chase yaw guidance block.
`timescale 1ns / 1ps

module carrot_chase_yaw_guidance_tb;

  localparam longint PI_A      = 205887;
  localparam longint HALF_PI_A = 102944;
  localparam longint TURN_A    = 411775;
  localparam longint INV_GAIN_A = 652032874;
  localparam int     N_ITER    = 16;
  localparam int     SETTLE    = 120;

  typedef struct {
    bit cmd;
    int px, py, ax, ay, ex, ey;
    bit left;
  } fix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ccyg_pkg::CFG_AW-1:0] cfg_idx = '0;
  logic [ccyg_pkg::CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0, turn_left = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, anchor_x = '0, anchor_y = '0;
  logic signed [31:0] end_x = '0, end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] desired_yaw;

  // Shadow of the block's configuration and yaw history.
  longint lookahead_r = 327680;
  longint lead_r = 51472;
  longint radius_r = 655360;
  longint last_yaw_r = 0;

  fix_t   fix_q[$];
  int     yaw_q[$];
  fix_t   cur;
  int     gap_cnt = 0;
  int     stall_cnt = 0;
  int     n_acc = 0;
  int     errors = 0;
  bit     calm = 1'b0;
  bit     long_hold_done = 1'b0;

  carrot_chase_yaw_guidance dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .pos_x_i(pos_x), .pos_y_i(pos_y),
    .anchor_x_i(anchor_x), .anchor_y_i(anchor_y),
    .end_x_i(end_x), .end_y_i(end_y), .turn_left_i(turn_left),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .desired_yaw_o(desired_yaw)
  );

  always #5 clk = ~clk;

  function automatic longint atan_step(int i);
    longint head[7] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024};
    if (i < 7) return head[i];
    if (i <= 16) return longint'(1) << (16 - i);
    return 0;
  endfunction

  function automatic longint strip_gain(longint v);
    longint unsigned a, hi, lo;
    longint r;
    a = (v < 0) ? longint'(-v) : v;
    hi = (a >> 16) * INV_GAIN_A;
    lo = ((a & 64'hFFFF) * INV_GAIN_A) >> 16;
    r = longint'((hi + lo) >> 14);
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint bearing(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_A : -PI_A;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < N_ITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    if (z > PI_A) z = PI_A;
    if (z < -PI_A) z = -PI_A;
    return z;
  endfunction

  // Rotation keeps the CORDIC gain; callers strip it where needed.
  task automatic rotate_vec(input longint x, input longint y, input longint a,
                            output longint ox, output longint oy);
    longint xs, ys;
    while (a > PI_A) a -= TURN_A;
    while (a < -PI_A) a += TURN_A;
    if (a > HALF_PI_A) begin
      a -= PI_A; x = -x; y = -y;
    end else if (a < -HALF_PI_A) begin
      a += PI_A; x = -x; y = -y;
    end
    for (int i = 0; i < N_ITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= atan_step(i);
      end else begin
        x += ys; y -= xs; a += atan_step(i);
      end
    end
    ox = x;
    oy = y;
  endtask

  task automatic predict_yaw(input fix_t f);
    longint px, py, ax, ay, rx, ry, theta, proj, yaw, d, off;
    px = f.px; py = f.py; ax = f.ax; ay = f.ay;
    if (!f.cmd) begin
      theta = bearing(longint'(f.ey) - ay, longint'(f.ex) - ax);
      rotate_vec(px - ax, py - ay, -theta, rx, ry);
      proj = strip_gain(rx);
      if (proj < 0) proj = -proj;
      rotate_vec(strip_gain(proj + lookahead_r), 0, theta, rx, ry);
    end else begin
      theta = bearing(py - ay, px - ax);
      theta = f.left ? theta + lead_r : theta - lead_r;
      rotate_vec(strip_gain(radius_r), 0, theta, rx, ry);
    end
    yaw = -bearing(ay + ry - py, ax + rx - px);
    d = yaw - last_yaw_r;
    if (d >= PI_A || d <= -PI_A) begin
      off = (d < 0) ? d - PI_A : d + PI_A;
      yaw -= TURN_A * (off / TURN_A);
    end
    if (yaw > 64'sd2147483647) yaw = 64'sd2147483647;
    if (yaw < -64'sd2147483648) yaw = -64'sd2147483648;
    last_yaw_r = yaw;
    yaw_q.push_back(int'(yaw));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // Driver: one item offered at a time, held until accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 199) == 0) calm <= ~calm;
      if (in_valid && in_ready) begin
        predict_yaw(cur);
        n_acc <= n_acc + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (fix_q.size() > 0) begin
          cur = fix_q.pop_front();
          cmd <= cur.cmd; turn_left <= cur.left;
          pos_x <= cur.px; pos_y <= cur.py;
          anchor_x <= cur.ax; anchor_y <= cur.ay;
          end_x <= cur.ex; end_y <= cur.ey;
          in_valid <= 1'b1;
          gap_cnt <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold so the block fills up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && n_acc == 40) begin
        long_hold_done <= 1'b1;
        stall_cnt <= 600;
        out_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30)
          stall_cnt <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 4);
      end
    end
  end

  // Monitor: compare each delivered yaw with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (yaw_q.size() == 0) begin
        $display("%0t: unexpected item, desired_yaw actual %0d", $time, desired_yaw);
        errors++;
      end else if (yaw_q[0] != desired_yaw) begin
        $display("%0t: desired_yaw mismatch, expected %0d actual %0d",
                 $time, yaw_q[0], desired_yaw);
        errors++;
        void'(yaw_q.pop_front());
      end else begin
        void'(yaw_q.pop_front());
      end
    end
  end

  function automatic fix_t mk(bit c, int px, int py, int ax, int ay,
                              int ex, int ey, bit l);
    fix_t f;
    f.cmd = c; f.px = px; f.py = py; f.ax = ax; f.ay = ay;
    f.ex = ex; f.ey = ey; f.left = l;
    return f;
  endfunction

  // Mostly local geometry around a random anchor; some fully random fixes.
  function automatic fix_t rand_fix();
    fix_t f;
    int bx, by;
    f.cmd = $urandom_range(0, 1);
    f.left = $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 2) begin
      f.px = $urandom; f.py = $urandom; f.ax = $urandom;
      f.ay = $urandom; f.ex = $urandom; f.ey = $urandom;
    end else begin
      bx = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      by = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      f.ax = bx;
      f.ay = by;
      f.px = bx + $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
      f.py = by + $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
      f.ex = bx + $signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
      f.ey = by + $signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
    end
    return f;
  endfunction

  task automatic cfg_write(input logic [ccyg_pkg::CFG_AW-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[ccyg_pkg::CFG_DW-1:0];
    case (idx)
      ccyg_pkg::REG_LOOKAHEAD: lookahead_r = val & 64'h7FFF_FFFF;
      ccyg_pkg::REG_LEAD:      lead_r = val & 64'h3_FFFF;
      ccyg_pkg::REG_RADIUS:    radius_r = val & 64'h7FFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic set_config(input longint la, input longint ld, input longint rd);
    cfg_write(ccyg_pkg::REG_LOOKAHEAD, la);
    cfg_write(ccyg_pkg::REG_LEAD, ld);
    cfg_write(ccyg_pkg::REG_RADIUS, rd);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (fix_q.size() > 0 || in_valid || yaw_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) fix_q.push_back(rand_fix());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, both segment kinds and the corner geometries.
    fix_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));              // zero-length line
    fix_q.push_back(mk(0, 32'sh0005_0000, 32'sh0003_0000, 7, 7, 7, 7, 1));
    fix_q.push_back(mk(0, -32'sh0010_0000, 0, 0, 0, 32'sh0010_0000, 0, 0)); // behind start
    fix_q.push_back(mk(0, 32'sh0001_0000, -32'sh0004_0000, 0, 0, 0, 32'sh0008_0000, 0));
    fix_q.push_back(mk(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1));
    fix_q.push_back(mk(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh8000_0000, 0));
    fix_q.push_back(mk(0, -1, -1, -1, -1, -1, -1, 1));
    fix_q.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1));              // on circle centre
    fix_q.push_back(mk(1, 32'sh0004_0000, 0, 0, 0, 0, 0, 1));
    fix_q.push_back(mk(1, 32'sh0004_0000, 0, 0, 0, 0, 0, 0));
    fix_q.push_back(mk(1, -32'sh0004_0000, -5, 0, 0, 0, 0, 1));
    fix_q.push_back(mk(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    fix_q.push_back(mk(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       0, 0, 1));
    queue_random(60);
    wait_drained();

    set_config(0, 0, 0);
    fix_q.push_back(mk(1, 32'sh0002_0000, 32'sh0002_0000, 0, 0, 0, 0, 1));
    queue_random(60);
    wait_drained();

    // Upper extremes; the lead here exceeds pi and must wrap.
    set_config(64'h7FFF_FFFF, 64'h3_FFFF, 64'h7FFF_FFFF);
    fix_q.push_back(mk(1, 32'sh0002_0000, -32'sh0002_0000, 0, 0, 0, 0, 0));
    queue_random(60);
    wait_drained();

    repeat (4) begin
      set_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                             : $urandom_range(0, 32'h00FF_FFFF),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h3_FFFF)
                                             : $urandom_range(0, 205887),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                             : $urandom_range(0, 32'h01FF_FFFF));
      queue_random(55);
      wait_drained();
    end

    if (errors == 0) begin
      $display("carrot_chase_yaw_guidance verification clean");
    end else begin
      $display("carrot_chase_yaw_guidance verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("carrot_chase_yaw_guidance verification failed");
    $finish;
  end

endmodule
